// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/ecc_pkg.sv
package ecc_pkg;

  // Input item
  typedef struct packed {
    logic        opcode;
    logic [31:0] in_seconds;
    logic [5:0]  in_second;
    logic [5:0]  in_minute;
    logic [4:0]  in_hour;
    logic [4:0]  in_day_of_month;
    logic [3:0]  in_month;
    logic [7:0]  in_year;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [31:0] out_seconds;
    logic [5:0]  out_second;
    logic [5:0]  out_minute;
    logic [4:0]  out_hour;
    logic [2:0]  out_weekday;
    logic [4:0]  out_day_of_month;
    logic [3:0]  out_month;
    logic [7:0]  out_year;
  } out_item_t;

  // Operation select on the input transfer
  localparam logic OpToFields  = 1'b0;
  localparam logic OpToSeconds = 1'b1;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_SPLIT_SEC,
    DP_SPLIT_MIN,
    DP_SPLIT_DAY,
    DP_WDAY,
    DP_YEAR_STEP,
    DP_MON_INIT,
    DP_MON_STEP,
    DP_F_LEAP_STEP,
    DP_F_MON_INIT,
    DP_F_MON_STEP,
    DP_F_DAY,
    DP_F_HOUR,
    DP_F_MIN,
    DP_F_SEC
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ecc_cmd_t;

  typedef struct packed {
    logic year_fit;   // remaining days fall inside current year
    logic mon_fit;    // remaining days fall inside current month
    logic leap_done;  // leap-day scan reached target year
    logic fmon_done;  // month accumulation reached target month
  } ecc_status_t;

  // Time constants
  localparam logic [31:0] SecPerMin  = 32'd60;
  localparam logic [31:0] SecPerHour = 32'd3600;
  localparam logic [31:0] SecPerDay  = 32'd86400;
  localparam logic [31:0] SecPerYear = 32'd365 * SecPerDay;
  localparam logic [7:0]  EpochYear  = 8'd70;   // 1970 as years since 1900
  localparam logic [15:0] EpochWday  = 16'd4;   // 1 Jan 1970 was a Thursday

  // Reciprocals for division by constants
  localparam logic [31:0] Recip60 = 32'h8888_8889;  // ceil(2^37 / 60), 32-bit dividend
  localparam logic [17:0] Recip3  = 18'h2_AAAB;     // ceil(2^19 / 3), 18-bit dividend
  localparam logic [16:0] Recip7  = 17'd74899;      // ceil(2^19 / 7), 16-bit dividend

  // Gregorian rule over 1900..2155: century years 1900 and 2100 are common
  function automatic logic is_leap_f(logic [7:0] yr);
    return (yr[1:0] == 2'b00) && (yr != 8'd0) && (yr != 8'd200);
  endfunction

  // Days in month m (January = 0)
  function automatic logic [4:0] days_in_month_f(logic [3:0] m, logic leap);
    logic [4:0] len;
    if (m == 4'd1) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// File: hw/rtl/ecc_dp.sv
module ecc_dp (
  input  logic               clk_i,
  input  ecc_pkg::ecc_cmd_t  cmd_i,
  input  ecc_pkg::in_item_t  in_data_i,
  output ecc_pkg::ecc_status_t status_o,
  output ecc_pkg::out_item_t result_o
);
  import ecc_pkg::*;

  in_item_t    item_q;
  logic [31:0] acc_q;    // seconds being split, or running seconds total
  logic [15:0] days_q;
  logic [7:0]  year_q;
  logic [3:0]  mon_q;
  logic [7:0]  cnt_q;
  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [4:0]  hour_q;
  logic [2:0]  wday_q;

  logic [63:0] div60_prod;
  logic [26:0] div60_q;
  logic [5:0]  div60_r;
  logic [35:0] div24_prod;
  logic [15:0] div24_q;
  logic [4:0]  div24_r;
  logic [15:0] wday_num;
  logic [32:0] div7_prod;
  logic [13:0] div7_q;
  logic [2:0]  div7_r;
  logic        leap_y;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [3:0]  mo_cap;
  logic [31:0] year_term;
  logic [31:0] fmon_add;
  logic [31:0] day_add;
  logic [31:0] hour_add;
  logic [31:0] min_add;

  // acc_q / 60 by reciprocal multiply; remainder is below 64, so 6 bits do
  assign div60_prod = 64'(acc_q) * 64'(Recip60);
  assign div60_q    = div60_prod[63:37];
  assign div60_r    = acc_q[5:0] - (div60_q[5:0] * 6'd60);

  // acc_q / 24 as (acc_q / 8) / 3; acc_q is below 2^21 at this point
  assign div24_prod = 36'(acc_q[20:3]) * 36'(Recip3);
  assign div24_q    = div24_prod[34:19];
  assign div24_r    = acc_q[4:0] - (div24_q[4:0] * 5'd24);

  // Weekday: (days + 4) mod 7, days at most 49710
  assign wday_num  = days_q + EpochWday;
  assign div7_prod = 33'(wday_num) * 33'(Recip7);
  assign div7_q    = div7_prod[32:19];
  assign div7_r    = wday_num[2:0] - (div7_q[2:0] * 3'd7);

  // Calendar lookups
  assign leap_y = is_leap_f(year_q);
  assign ylen   = leap_y ? 9'd365 + 9'd1 : 9'd365;
  assign mlen   = days_in_month_f(mon_q, leap_y);
  assign mo_cap = (item_q.in_month > 4'd12) ? 4'd12 : item_q.in_month;

  // Product terms, one used per cycle
  assign year_term = ({24'b0, in_data_i.in_year} - {24'b0, EpochYear}) * SecPerYear;
  assign fmon_add  = {27'b0, days_in_month_f(cnt_q[3:0], is_leap_f(item_q.in_year))}
                     * SecPerDay;
  assign day_add   = ({27'b0, item_q.in_day_of_month} - 32'd1) * SecPerDay;
  assign hour_add  = {27'b0, item_q.in_hour} * SecPerHour;
  assign min_add   = {26'b0, item_q.in_minute} * SecPerMin;

  // Status to controller
  always_comb begin
    status_o.year_fit  = (days_q < {7'b0, ylen});
    status_o.mon_fit   = (mon_q == 4'd11) || (days_q < {11'b0, mlen});
    status_o.leap_done = (cnt_q >= item_q.in_year);
    status_o.fmon_done = (cnt_q >= {4'b0, mo_cap});
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        item_q <= in_data_i;
        acc_q  <= (in_data_i.opcode == OpToSeconds) ? year_term : in_data_i.in_seconds;
        cnt_q  <= EpochYear;
      end
      DP_SPLIT_SEC: begin
        sec_q <= div60_r;
        acc_q <= {5'b0, div60_q};
      end
      DP_SPLIT_MIN: begin
        min_q <= div60_r;
        acc_q <= {5'b0, div60_q};
      end
      DP_SPLIT_DAY: begin
        hour_q <= div24_r;
        days_q <= div24_q;
      end
      DP_WDAY: begin
        wday_q <= div7_r;
        year_q <= EpochYear;
      end
      DP_YEAR_STEP: begin
        days_q <= days_q - {7'b0, ylen};
        year_q <= year_q + 8'd1;
      end
      DP_MON_INIT: begin
        mon_q <= '0;
      end
      DP_MON_STEP: begin
        days_q <= days_q - {11'b0, mlen};
        mon_q  <= mon_q + 4'd1;
      end
      DP_F_LEAP_STEP: begin
        if (is_leap_f(cnt_q)) begin
          acc_q <= acc_q + SecPerDay;
        end
        cnt_q <= cnt_q + 8'd1;
      end
      DP_F_MON_INIT: begin
        cnt_q <= '0;
      end
      DP_F_MON_STEP: begin
        acc_q <= acc_q + fmon_add;
        cnt_q <= cnt_q + 8'd1;
      end
      DP_F_DAY:  acc_q <= acc_q + day_add;
      DP_F_HOUR: acc_q <= acc_q + hour_add;
      DP_F_MIN:  acc_q <= acc_q + min_add;
      DP_F_SEC:  acc_q <= acc_q + {26'b0, item_q.in_second};
      default: begin
      end
    endcase
  end

  // Result assembly; unused fields read as zero
  always_comb begin
    result_o = '0;
    if (item_q.opcode == OpToSeconds) begin
      result_o.out_seconds = acc_q;
    end else begin
      result_o.out_second       = sec_q;
      result_o.out_minute       = min_q;
      result_o.out_hour         = hour_q;
      result_o.out_weekday      = wday_q;
      result_o.out_day_of_month = days_q[4:0] + 5'd1;
      result_o.out_month        = mon_q;
      result_o.out_year         = year_q;
    end
  end

endmodule

// File: hw/rtl/ecc_ctrl.sv
module ecc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 opcode_i,
  input  logic                 out_free_i,
  input  ecc_pkg::ecc_status_t status_i,
  output logic                 in_ready_o,
  output logic                 out_load_o,
  output ecc_pkg::ecc_cmd_t    cmd_o
);
  import ecc_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SPLIT_SEC = 4'd1;
  localparam logic [3:0] S_SPLIT_MIN = 4'd2;
  localparam logic [3:0] S_SPLIT_DAY = 4'd3;
  localparam logic [3:0] S_WDAY      = 4'd4;
  localparam logic [3:0] S_YEAR      = 4'd5;
  localparam logic [3:0] S_MONTH     = 4'd6;
  localparam logic [3:0] S_F_YEAR    = 4'd7;
  localparam logic [3:0] S_F_MONTH   = 4'd8;
  localparam logic [3:0] S_F_HOUR    = 4'd9;
  localparam logic [3:0] S_F_MIN     = 4'd10;
  localparam logic [3:0] S_F_SEC     = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencing
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = DP_NOP;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = (opcode_i == OpToSeconds) ? S_F_YEAR : S_SPLIT_SEC;
        end
      end
      // Split seconds, minutes, hours and days, then find the weekday, one stage per cycle
      S_SPLIT_SEC: begin
        cmd_o.op = DP_SPLIT_SEC;
        state_d  = S_SPLIT_MIN;
      end
      S_SPLIT_MIN: begin
        cmd_o.op = DP_SPLIT_MIN;
        state_d  = S_SPLIT_DAY;
      end
      S_SPLIT_DAY: begin
        cmd_o.op = DP_SPLIT_DAY;
        state_d  = S_WDAY;
      end
      S_WDAY: begin
        cmd_o.op = DP_WDAY;
        state_d  = S_YEAR;
      end
      // Peel whole years off the day count
      S_YEAR: begin
        if (status_i.year_fit) begin
          cmd_o.op = DP_MON_INIT;
          state_d  = S_MONTH;
        end else begin
          cmd_o.op = DP_YEAR_STEP;
        end
      end
      S_MONTH: begin
        if (status_i.mon_fit) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = DP_MON_STEP;
        end
      end
      // Add one leap day per leap year since 1970
      S_F_YEAR: begin
        if (status_i.leap_done) begin
          cmd_o.op = DP_F_MON_INIT;
          state_d  = S_F_MONTH;
        end else begin
          cmd_o.op = DP_F_LEAP_STEP;
        end
      end
      S_F_MONTH: begin
        if (status_i.fmon_done) begin
          cmd_o.op = DP_F_DAY;
          state_d  = S_F_HOUR;
        end else begin
          cmd_o.op = DP_F_MON_STEP;
        end
      end
      S_F_HOUR: begin
        cmd_o.op = DP_F_HOUR;
        state_d  = S_F_MIN;
      end
      S_F_MIN: begin
        cmd_o.op = DP_F_MIN;
        state_d  = S_F_SEC;
      end
      S_F_SEC: begin
        cmd_o.op = DP_F_SEC;
        state_d  = S_DONE;
      end
      // Hand result to the output register once it has room
      S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/epoch_calendar_converter.sv
// Seconds to fields: after the load the input is split into seconds, minutes, hours
// and days, the weekday is found, then whole years and months come off the day count.
// Fields to seconds: leap days, then whole months are added in scan loops, then the
// day, hour, minute and second terms. One transfer is in flight; the next input is
// taken once the controller is back in idle, after the result enters the output
// register. Reset (rst_ni, async low) idles the controller.
`include "assert_macros.svh"

module epoch_calendar_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ecc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ecc_pkg::out_item_t out_data_o
);
  import ecc_pkg::*;

  ecc_cmd_t    cmd;
  ecc_status_t status;
  out_item_t   result;
  out_item_t   out_q;
  logic        out_valid_q;
  logic        out_free;
  logic        out_load;

  assign out_free = !out_valid_q || out_ready_i;

  ecc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_data_i.opcode),
    .out_free_i (out_free),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  ecc_dp u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .status_o  (status),
    .result_o  (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_load, !out_valid_q || out_ready_i)
  `ASSERT_IMP(a_month_range, clk_i, rst_ni, out_valid_o, out_data_o.out_month < 4'd12)
endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecc_pkg::*;

  // Cycles without any transfer before the run is declared hung
  localparam int unsigned STALL_LIMIT  = 20000;
  // Worst-case conversion latency plus margin
  localparam int unsigned DRAIN_CYCLES = 250;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  out_item_t expected_results[$];

  epoch_calendar_converter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gregorian leap rule on a full calendar year
  function automatic logic gregorian_leap(input int unsigned full_year);
    if (full_year % 4 != 0) return 1'b0;
    if (full_year % 100 != 0) return 1'b1;
    return (full_year % 400) == 0;
  endfunction

  function automatic logic [31:0] month_days(input int unsigned month,
                                             input int unsigned full_year);
    logic [31:0] len;
    case (month % 12)
      1: len = gregorian_leap(full_year) ? 32'd29 : 32'd28;
      3, 5, 8, 10: len = 32'd30;
      default: len = 32'd31;
    endcase
    return len;
  endfunction

  // Expected result of one conversion
  function automatic out_item_t convert_epoch(input in_item_t it);
    out_item_t   res;
    logic [31:0] t;
    logic [31:0] days;
    logic [31:0] total;
    logic [31:0] yy;
    logic [31:0] mo;
    logic [31:0] dd;
    int unsigned year;
    int unsigned month;
    int unsigned i;
    res = '0;
    if (it.opcode == OpToFields) begin
      t = it.in_seconds;
      res.out_second = 6'(t % 60);
      t = t / 60;
      res.out_minute = 6'(t % 60);
      t = t / 60;
      res.out_hour = 5'(t % 24);
      days = t / 24;
      res.out_weekday = 3'((days + 32'd4) % 7);
      year = 1970;
      while (days >= (gregorian_leap(year) ? 32'd366 : 32'd365)) begin
        days = days - (gregorian_leap(year) ? 32'd366 : 32'd365);
        year++;
      end
      month = 0;
      while (month < 11 && days >= month_days(month, year)) begin
        days = days - month_days(month, year);
        month++;
      end
      res.out_day_of_month = 5'(days + 32'd1);
      res.out_month = 4'(month);
      res.out_year = 8'(year - 1900);
    end else begin
      yy = 32'(it.in_year);
      // years before 1970 wrap and get no leap days
      total = (yy - 32'd70) * (SecPerDay * 32'd365);
      for (i = 70; i < yy; i++) begin
        if (gregorian_leap(1900 + i)) total = total + SecPerDay;
      end
      mo = 32'(it.in_month);
      if (mo > 32'd12) mo = 32'd12;
      for (i = 0; i < mo; i++) begin
        total = total + SecPerDay * month_days(i, 1900 + yy);
      end
      dd = 32'(it.in_day_of_month);
      total = total + (dd - 32'd1) * SecPerDay;
      total = total + SecPerHour * 32'(it.in_hour);
      total = total + SecPerMin * 32'(it.in_minute);
      total = total + 32'(it.in_second);
      res.out_seconds = total;
    end
    return res;
  endfunction

  function automatic in_item_t seconds_item(input logic [31:0] t);
    in_item_t it;
    it = '0;
    it.opcode = OpToFields;
    it.in_seconds = t;
    it.in_year = 8'($urandom);
    it.in_month = 4'($urandom);
    it.in_day_of_month = 5'($urandom);
    return it;
  endfunction

  function automatic in_item_t fields_item(input logic [7:0] yr, input logic [3:0] mo,
                                           input logic [4:0] dd, input logic [4:0] hh,
                                           input logic [5:0] mm, input logic [5:0] ss);
    in_item_t it;
    it.opcode = OpToSeconds;
    it.in_seconds = $urandom;
    it.in_year = yr;
    it.in_month = mo;
    it.in_day_of_month = dd;
    it.in_hour = hh;
    it.in_minute = mm;
    it.in_second = ss;
    return it;
  endfunction

  // Mostly valid calendar fields, some raw noise across full widths
  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode = 1'($urandom_range(1));
    it.in_seconds = $urandom;
    if ($urandom_range(99) < 85) begin
      it.in_year = 8'($urandom_range(206, 70));
      it.in_month = 4'($urandom_range(11));
      it.in_day_of_month =
        5'($urandom_range(month_days(it.in_month, 1900 + it.in_year), 1));
      it.in_hour = 5'($urandom_range(23));
      it.in_minute = 6'($urandom_range(59));
      it.in_second = 6'($urandom_range(59));
    end else begin
      it.in_year = 8'($urandom);
      it.in_month = 4'($urandom);
      it.in_day_of_month = 5'($urandom);
      it.in_hour = 5'($urandom);
      it.in_minute = 6'($urandom);
      it.in_second = 6'($urandom);
    end
    return it;
  endfunction

  // Send one transfer; entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(convert_epoch(it));
    @(negedge clk);
  endtask

  // Hold off the sender until every pending result is back
  task automatic wait_for_results();
    if (expected_results.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clk);
    end
  endtask

  task automatic test_seconds_edges();
    send_item(seconds_item(32'd0));
    send_item(seconds_item(32'd86399));
    send_item(seconds_item(32'd86400));
    send_item(seconds_item(32'd946684799));   // last second of 1999
    send_item(seconds_item(32'd951782400));   // leap day 2000
    send_item(seconds_item(32'd951868800));
    send_item(seconds_item(32'd4107456000));  // 2100 is a common year
    send_item(seconds_item(32'd4107542400));
    send_item(seconds_item(32'h7FFF_FFFF));
    send_item(seconds_item(32'hFFFF_FFFF));
  endtask

  task automatic test_fields_edges();
    send_item(fields_item(8'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0));
    send_item(fields_item(8'd206, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59));
    send_item(fields_item(8'd100, 4'd1, 5'd29, 5'd12, 6'd30, 6'd30));
    send_item(fields_item(8'd200, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0));
    // year before the epoch
    send_item(fields_item(8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0));
    send_item(fields_item(8'd69, 4'd6, 5'd15, 5'd8, 6'd20, 6'd40));
    // month past December, day zero, oversized time of day
    send_item(fields_item(8'd120, 4'd12, 5'd5, 5'd1, 6'd2, 6'd3));
    send_item(fields_item(8'd90, 4'd5, 5'd0, 5'd10, 6'd10, 6'd10));
    send_item(fields_item(8'd75, 4'd3, 5'd15, 5'd31, 6'd63, 6'd63));
    send_item(fields_item(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall_pct, input int unsigned drain_every);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned n = 1; n <= count; n++) begin
      send_item(random_item());
      if (drain_every != 0 && n % drain_every == 0) wait_for_results();
    end
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result check and hang watchdog
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing pending");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("out_seconds", want.out_seconds, out_data.out_seconds);
          compare_field("out_second", 32'(want.out_second), 32'(out_data.out_second));
          compare_field("out_minute", 32'(want.out_minute), 32'(out_data.out_minute));
          compare_field("out_hour", 32'(want.out_hour), 32'(out_data.out_hour));
          compare_field("out_weekday", 32'(want.out_weekday), 32'(out_data.out_weekday));
          compare_field("out_day_of_month", 32'(want.out_day_of_month),
                        32'(out_data.out_day_of_month));
          compare_field("out_month", 32'(want.out_month), 32'(out_data.out_month));
          compare_field("out_year", 32'(want.out_year), 32'(out_data.out_year));
        end
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_seconds_edges();
    test_fields_edges();
    test_random(210, 0, 0, 0);
    test_random(210, 88, 0, 0);
    test_random(210, 0, 88, 0);
    test_random(210, 27, 27, 50);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ecc_pkg.sv
hw/rtl/ecc_dp.sv
hw/rtl/ecc_ctrl.sv
hw/rtl/epoch_calendar_converter.sv
sim/tb.sv
